### design/olde_pkg.sv
// Shared types, constants and codes of the ordered list dedupe engine.
package olde_pkg;

  localparam int LIST_DEPTH    = 16;
  localparam int IDX_W         = $clog2(LIST_DEPTH);
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int DATA_W        = 32;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_DEDUPE = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_R_RD,
    S_R_CMP,
    S_SH_CHK,
    S_SH_WR,
    S_D_RD,
    S_D_LAT,
    S_D_CHK,
    S_D_CMP,
    S_D_NEXT,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_I,
    RD_K,
    RD_K1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_CNT_VAL,
    WR_K_RDATA,
    WR_KEPT_CUR
  } wr_sel_e;

  typedef struct packed {
    logic [MODE_W-1:0]          mode;
    logic signed [DATA_W-1:0]   value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic    latch_in;
    logic    set_st;
    status_e st_val;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_load_kept;
    logic    i_clr;
    logic    i_inc;
    logic    k_from_i;
    logic    k_clr;
    logic    k_inc;
    logic    kept_clr;
    logic    kept_inc;
    logic    cur_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              i_last;
    logic              k_last;
    logic              k_eq_kept;
    logic              hit_val;
    logic              hit_cur;
    logic              out_free;
  } stat_t;

endpackage

### design/ordered_list_dedupe_engine.sv
// Top level of the ordered list dedupe engine: controller plus datapath.
//
// Holds an ordered list of up to LIST_DEPTH signed 32-bit entries in a RAM.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one operation
// per transaction: append, remove first match, or dedupe. Output channel
// (out_valid_o / out_ready_i / out_data_o) returns one status and the entry
// count for every input transaction, in order.
// One item is worked on at a time; the RAM has one read and one write port
// and each compare costs a registered read. Append, mode 3 and any
// empty-list case go straight from dispatch to the final step; remove
// searches for the first match, then shifts the later entries down (search
// plus shift walk the list once); dedupe compares each entry with the kept
// prefix and compacts first occurrences into it.
// The controller then returns to idle, where the next transaction is taken
// even while the previous result still waits in the output register; if the
// receiver stalls, the block finishes its item and holds in the final step
// until the output register frees.
// Reset clears the entry count and the output valid; RAM contents are left
// as they are and only entries below the count are ever read.
module ordered_list_dedupe_engine import olde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  olde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  olde_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

### design/olde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olde_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/olde_ctrl.sv
// Controller state machine of the ordered list dedupe engine.
module olde_ctrl import olde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.mode)
          MODE_REMOVE: state_d = stat_i.empty ? S_FINISH : S_R_RD;
          MODE_DEDUPE: state_d = stat_i.empty ? S_FINISH : S_D_RD;
          default:     state_d = S_FINISH;
        endcase
      end
      S_R_RD:   state_d = S_R_CMP;
      S_R_CMP: begin
        if (stat_i.hit_val)     state_d = S_SH_CHK;
        else if (stat_i.i_last) state_d = S_FINISH;
        else                    state_d = S_R_RD;
      end
      S_SH_CHK: state_d = stat_i.k_last ? S_FINISH : S_SH_WR;
      S_SH_WR:  state_d = S_SH_CHK;
      S_D_RD:   state_d = S_D_LAT;
      S_D_LAT:  state_d = S_D_CHK;
      S_D_CHK:  state_d = stat_i.k_eq_kept ? S_D_NEXT : S_D_CMP;
      S_D_CMP:  state_d = stat_i.hit_cur ? S_D_NEXT : S_D_CHK;
      S_D_NEXT: state_d = stat_i.i_last ? S_FINISH : S_D_RD;
      S_FINISH: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.latch_in  = in_valid_i;
      end
      S_DISPATCH: begin
        cmd_o.set_st   = 1'b1;
        cmd_o.st_val   = STAT_DONE;
        cmd_o.i_clr    = 1'b1;
        cmd_o.kept_clr = 1'b1;
        case (stat_i.mode)
          MODE_APPEND: begin
            if (stat_i.full) begin
              cmd_o.st_val = STAT_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_CNT_VAL;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          MODE_REMOVE: begin
            if (stat_i.empty) cmd_o.st_val = STAT_EMPTY;
          end
          default: ;
        endcase
      end
      S_R_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
      end
      S_R_CMP: begin
        if (stat_i.hit_val) begin
          cmd_o.k_from_i = 1'b1;
        end else if (stat_i.i_last) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st_val = STAT_NOT_FOUND;
        end else begin
          cmd_o.i_inc = 1'b1;
        end
      end
      S_SH_CHK: begin
        if (stat_i.k_last) begin
          cmd_o.cnt_dec = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_K1;
        end
      end
      S_SH_WR: begin
        // Move entry k+1 down into slot k.
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_K_RDATA;
        cmd_o.k_inc  = 1'b1;
      end
      S_D_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_I;
      end
      S_D_LAT: begin
        cmd_o.cur_load = 1'b1;
        cmd_o.k_clr    = 1'b1;
      end
      S_D_CHK: begin
        if (stat_i.k_eq_kept) begin
          // First occurrence: compact it into the kept prefix.
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_KEPT_CUR;
          cmd_o.kept_inc = 1'b1;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_K;
        end
      end
      S_D_CMP: begin
        if (!stat_i.hit_cur) cmd_o.k_inc = 1'b1;
      end
      S_D_NEXT: begin
        if (stat_i.i_last) cmd_o.cnt_load_kept = 1'b1;
        else               cmd_o.i_inc = 1'b1;
      end
      S_FINISH: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

### design/olde_dp.sv
// Datapath of the ordered list dedupe engine: counters, entry RAM, compares, output register.
module olde_dp import olde_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output out_t out_data_o,
  input  cmd_t cmd_i,
  output stat_t stat_o
);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  i_q, i_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  kept_q, kept_d;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  k_p1;
  logic [MODE_W-1:0] mode_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] cur_q;
  status_e           st_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;

  logic              re;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;

  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign k_p1   = k_q + CNT_W'(1);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc)            cnt_d = cnt_q + CNT_W'(1);
    else if (cmd_i.cnt_dec)       cnt_d = cnt_m1;
    else if (cmd_i.cnt_load_kept) cnt_d = kept_q;

    i_d = i_q;
    if (cmd_i.i_clr)      i_d = '0;
    else if (cmd_i.i_inc) i_d = i_q + CNT_W'(1);

    k_d = k_q;
    if (cmd_i.k_from_i)   k_d = i_q;
    else if (cmd_i.k_clr) k_d = '0;
    else if (cmd_i.k_inc) k_d = k_p1;

    kept_d = kept_q;
    if (cmd_i.kept_clr)      kept_d = '0;
    else if (cmd_i.kept_inc) kept_d = kept_q + CNT_W'(1);

    out_valid_d = out_valid_q;
    if (cmd_i.load_out)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      kept_q      <= '0;
      st_q        <= STAT_DONE;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      k_q         <= k_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.set_st) st_q <= cmd_i.st_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q <= in_data_i.mode;
      val_q  <= in_data_i.value;
    end
    if (cmd_i.cur_load) cur_q <= rdata;
    if (cmd_i.load_out) begin
      out_q.status      <= st_q;
      out_q.entry_count <= ENTRY_COUNT_W'(cnt_q);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_K:    raddr = k_q[IDX_W-1:0];
      RD_K1:   raddr = k_p1[IDX_W-1:0];
      default: raddr = i_q[IDX_W-1:0];
    endcase
    case (cmd_i.wr_sel)
      WR_K_RDATA: begin
        waddr = k_q[IDX_W-1:0];
        wdata = rdata;
      end
      WR_KEPT_CUR: begin
        waddr = kept_q[IDX_W-1:0];
        wdata = cur_q;
      end
      default: begin
        waddr = cnt_q[IDX_W-1:0];
        wdata = val_q;
      end
    endcase
  end

  assign re = cmd_i.rd_en;
  assign we = cmd_i.wr_en;

  olde_ram #(
    .Width (DATA_W),
    .Depth (LIST_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign stat_o.mode      = mode_q;
  assign stat_o.full      = (cnt_q == CNT_W'(LIST_DEPTH));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.i_last    = (i_q == cnt_m1);
  assign stat_o.k_last    = (k_q == cnt_m1);
  assign stat_o.k_eq_kept = (k_q == kept_q);
  assign stat_o.hit_val   = (rdata == val_q);
  assign stat_o.hit_cur   = (rdata == cur_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
